[src/sdsh_pkg.sv]
`default_nettype none

package sdsh_pkg;

  localparam int unsigned SECTOR_BYTES   = 512;
  localparam int unsigned WAKE_BYTES     = 200;
  localparam int unsigned RESPONSE_POLLS = 128;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_BYTE = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_IDLE   = 3'd1;
  localparam logic [2:0] ST_BLKLEN_REJ = 3'd2;
  localparam logic [2:0] ST_CRCOFF_REJ = 3'd3;
  localparam logic [2:0] ST_READ_FAIL  = 3'd4;

  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_IF    = 6'd8;
  localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
  localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
  localparam logic [5:0] CMD_APP_OP     = 6'd41;
  localparam logic [5:0] CMD_APP_CMD    = 6'd55;
  localparam logic [5:0] CMD_CRC_ON_OFF = 6'd59;

  localparam logic [7:0]  CMD_START    = 8'h40;
  localparam logic [7:0]  CRC_POLY     = 8'h09;
  localparam logic [7:0]  IDLE_BYTE    = 8'hFF;
  localparam logic [7:0]  DATA_TOKEN   = 8'hFE;
  localparam logic [7:0]  R1_IDLE      = 8'h01;
  localparam logic [7:0]  R1_READY     = 8'h00;
  localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
  localparam logic [31:0] ARG_BLKLEN   = 32'd512;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sector;
    logic [7:0]  rx_byte;
  } sdsh_in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       select_active;
    logic       fast_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       done_res;
    logic [2:0] status;
  } sdsh_out_t;

  function automatic logic [7:0] crc7_step(logic [7:0] crc_in, logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] dat;
    crc = crc_in;
    dat = data_in;
    for (int k = 0; k < 8; k++) begin
      crc = {crc[6:0], 1'b0};
      if (dat[7] ^ crc[7]) begin
        crc = crc ^ CRC_POLY;
      end
      dat = {dat[6:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

[src/sdsh_out_reg.sv]
`default_nettype none

module sdsh_out_reg
  import sdsh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire sdsh_out_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output sdsh_out_t      out_item_o
);

  logic      vld_q;
  logic      vld_d;
  sdsh_out_t item_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (free_o) begin
      vld_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

[src/sdsh_seq.sv]
`default_nettype none

module sdsh_seq
  import sdsh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_en_i,
  input  wire sdsh_in_t item_i,
  output logic          res_valid_o,
  output sdsh_out_t     res_o
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_WAKE       = 4'd1;
  localparam logic [3:0] PH_CMD        = 4'd2;
  localparam logic [3:0] PH_POLL       = 4'd3;
  localparam logic [3:0] PH_WAIT       = 4'd4;
  localparam logic [3:0] PH_TOKEN      = 4'd5;
  localparam logic [3:0] PH_DATA       = 4'd6;
  localparam logic [3:0] PH_TRAIL_OK   = 4'd7;
  localparam logic [3:0] PH_TRAIL_FAIL = 4'd8;

  localparam logic [2:0] FRAME_CRC = 3'd6;

  logic [3:0]  phase_q, phase_d;
  logic [9:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  poll_q, poll_d;
  logic [5:0]  cmd_idx_q, cmd_idx_d;
  logic [31:0] arg_q, arg_d;
  logic [2:0]  frame_q, frame_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  last_resp_q, last_resp_d;
  logic        speed_q, speed_d;
  logic        select_q, select_d;

  logic [10:0] byte_cnt_inc;
  logic [2:0]  frame_inc;
  logic [7:0]  frame_byte;
  logic [7:0]  rx;
  logic        do_ff;
  logic        do_finish;
  logic [2:0]  fin_status;
  logic        do_start;
  logic [5:0]  start_idx;
  logic [31:0] start_arg;
  logic        is_last;

  assign rx           = item_i.rx_byte;
  assign byte_cnt_inc = {1'b0, byte_cnt_q} + 11'd1;
  assign frame_inc    = frame_q + 3'd1;

  always_comb begin
    case (frame_inc)
      3'd1:    frame_byte = CMD_START | {2'b00, cmd_idx_q};
      3'd2:    frame_byte = arg_q[31:24];
      3'd3:    frame_byte = arg_q[23:16];
      3'd4:    frame_byte = arg_q[15:8];
      3'd5:    frame_byte = arg_q[7:0];
      3'd6:    frame_byte = {crc_q[6:0], 1'b1};
      default: frame_byte = IDLE_BYTE;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    poll_d      = poll_q;
    cmd_idx_d   = cmd_idx_q;
    arg_d       = arg_q;
    frame_d     = frame_q;
    crc_d       = crc_q;
    last_resp_d = last_resp_q;
    speed_d     = speed_q;
    select_d    = select_q;

    res_valid_o = 1'b0;
    res_o       = '0;
    do_ff       = 1'b0;
    do_finish   = 1'b0;
    fin_status  = ST_OK;
    do_start    = 1'b0;
    start_idx   = CMD_GO_IDLE;
    start_arg   = '0;
    is_last     = 1'b0;

    case (item_i.mode)
      MODE_INIT: begin
        speed_d     = 1'b0;
        select_d    = 1'b0;
        byte_cnt_d  = '0;
        last_resp_d = IDLE_BYTE;
        phase_d     = PH_WAKE;
        do_ff       = 1'b1;
      end
      MODE_READ: begin
        select_d  = 1'b1;
        do_start  = 1'b1;
        start_idx = CMD_READ_BLOCK;
        start_arg = item_i.sector;
      end
      MODE_BYTE: begin
        case (phase_q)
          PH_WAKE: begin
            byte_cnt_d = byte_cnt_inc[9:0];
            if (byte_cnt_inc >= 11'(WAKE_BYTES)) begin
              select_d  = 1'b1;
              do_start  = 1'b1;
              start_idx = CMD_GO_IDLE;
            end else begin
              do_ff = 1'b1;
            end
          end
          PH_CMD: begin
            if (frame_q < FRAME_CRC) begin
              frame_d     = frame_inc;
              crc_d       = crc7_step(crc_q, frame_byte);
              res_valid_o = 1'b1;
              res_o.send_valid = 1'b1;
              res_o.send_byte  = frame_byte;
            end else begin
              phase_d = PH_POLL;
              poll_d  = '0;
              do_ff   = 1'b1;
            end
          end
          PH_POLL: begin
            if (rx != IDLE_BYTE || poll_q >= 8'(RESPONSE_POLLS)) begin
              last_resp_d = rx;
              phase_d     = PH_WAIT;
              case (cmd_idx_q)
                CMD_GO_IDLE: begin
                  if (rx != R1_IDLE) begin
                    do_finish  = 1'b1;
                    fin_status = ST_NOT_IDLE;
                  end
                end
                CMD_SET_BLKLEN: begin
                  if (rx != R1_READY) begin
                    do_finish  = 1'b1;
                    fin_status = ST_BLKLEN_REJ;
                  end
                end
                CMD_CRC_ON_OFF: begin
                  if (rx != R1_READY) begin
                    do_finish  = 1'b1;
                    fin_status = ST_CRCOFF_REJ;
                  end
                end
                CMD_READ_BLOCK: begin
                  if (rx != R1_READY) begin
                    phase_d = PH_TRAIL_FAIL;
                    poll_d  = '0;
                  end else begin
                    phase_d = PH_TOKEN;
                  end
                  do_ff = 1'b1;
                end
                default: ;
              endcase
            end else begin
              poll_d = poll_q + 8'd1;
              do_ff  = 1'b1;
            end
          end
          PH_TOKEN: begin
            if (rx == DATA_TOKEN) begin
              phase_d    = PH_DATA;
              byte_cnt_d = '0;
            end else if (rx != IDLE_BYTE) begin
              phase_d = PH_TRAIL_FAIL;
              poll_d  = '0;
            end
            do_ff = 1'b1;
          end
          PH_DATA: begin
            is_last = byte_cnt_inc >= 11'(SECTOR_BYTES);
            if (is_last) begin
              phase_d = PH_TRAIL_OK;
              poll_d  = '0;
            end else begin
              byte_cnt_d = byte_cnt_inc[9:0];
            end
            res_valid_o      = 1'b1;
            res_o.send_valid = 1'b1;
            res_o.send_byte  = IDLE_BYTE;
            res_o.data_valid = 1'b1;
            res_o.data_byte  = rx;
            res_o.data_last  = is_last;
          end
          PH_TRAIL_OK, PH_TRAIL_FAIL: begin
            if (poll_q == '0) begin
              poll_d = 8'd1;
              do_ff  = 1'b1;
            end else begin
              select_d   = 1'b0;
              do_finish  = 1'b1;
              fin_status = (phase_q == PH_TRAIL_OK) ? ST_OK : ST_READ_FAIL;
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (phase_q == PH_WAIT) begin
          case (cmd_idx_q)
            CMD_GO_IDLE: begin
              do_start  = 1'b1;
              start_idx = CMD_SEND_IF;
              start_arg = ARG_IF_COND;
            end
            CMD_SEND_IF, CMD_APP_OP: begin
              do_start = 1'b1;
              if (last_resp_q == R1_READY) begin
                start_idx = CMD_SET_BLKLEN;
                start_arg = ARG_BLKLEN;
              end else begin
                start_idx = CMD_APP_CMD;
              end
            end
            CMD_APP_CMD: begin
              do_start  = 1'b1;
              start_idx = CMD_APP_OP;
              start_arg = ARG_HCS;
            end
            CMD_SET_BLKLEN: begin
              do_start  = 1'b1;
              start_idx = CMD_CRC_ON_OFF;
            end
            CMD_CRC_ON_OFF: begin
              speed_d   = 1'b1;
              do_finish = 1'b1;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    endcase

    if (do_start) begin
      cmd_idx_d = start_idx;
      arg_d     = start_arg;
      frame_d   = '0;
      crc_d     = '0;
      phase_d   = PH_CMD;
      do_ff     = 1'b1;
    end
    if (do_ff) begin
      res_valid_o      = 1'b1;
      res_o.send_valid = 1'b1;
      res_o.send_byte  = IDLE_BYTE;
    end
    if (do_finish) begin
      phase_d          = PH_IDLE;
      res_valid_o      = 1'b1;
      res_o.send_valid = 1'b0;
      res_o.send_byte  = IDLE_BYTE;
      res_o.done_res   = 1'b1;
      res_o.status     = fin_status;
    end
    res_o.select_active = select_d;
    res_o.fast_clock    = speed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      byte_cnt_q  <= '0;
      poll_q      <= '0;
      cmd_idx_q   <= CMD_GO_IDLE;
      arg_q       <= '0;
      frame_q     <= '0;
      crc_q       <= '0;
      last_resp_q <= IDLE_BYTE;
      speed_q     <= 1'b0;
      select_q    <= 1'b0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      byte_cnt_q  <= byte_cnt_d;
      poll_q      <= poll_d;
      cmd_idx_q   <= cmd_idx_d;
      arg_q       <= arg_d;
      frame_q     <= frame_d;
      crc_q       <= crc_d;
      last_resp_q <= last_resp_d;
      speed_q     <= speed_d;
      select_q    <= select_d;
    end
  end

  a_data_requests_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.data_valid |-> res_o.send_valid && !res_o.done_res)
    else $error("data byte without next exchange");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.done_res |-> res_o.status == ST_OK)
    else $error("status without done");

  a_poll_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_POLL |-> poll_q <= 8'(RESPONSE_POLLS))
    else $error("poll counter overran");

  a_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q <= FRAME_CRC)
    else $error("frame position overran");

  a_fast_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(speed_q) |-> $past(step_en_i && res_valid_o && res_o.done_res))
    else $error("fast clock without init done");

endmodule

`default_nettype wire

[src/sd_card_spi_host_sequencer_top.sv]
// An accepted item passes through the input register and then the result register to its result item.
// Throughput: one item per cycle; a result waiting in the output register stalls the input
// register only when the output side is not ready.
// Items that cause no result update the state and produce nothing.
// Reset (rst_ni low, asynchronous): idle, card deselected, slow clock, both registers empty.

`default_nettype none

module sd_card_spi_host_sequencer_top
  import sdsh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire sdsh_in_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output sdsh_out_t      out_item_o
);

  logic      in_vld_q;
  logic      in_vld_d;
  sdsh_in_t  in_item_q;
  logic      out_free;
  logic      step_en;
  logic      res_valid;
  sdsh_out_t res;

  assign step_en    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  sdsh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdsh_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_en && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
